>>> sv/linear_interp_resampler_unit_macros.svh
// Assertion helpers for the resampler block.
`ifndef LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, reset masked.
`define LIRS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, reset masked.
`define LIRS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/lirs_pkg.sv
package lirs_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int STEP_W      = 21;
   localparam int CHAN_W      = 2;
   localparam int CSR_DATA_W  = 21;
   localparam int CSR_INDEX_W = 1;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
   localparam logic [CHAN_W-1:0] CHAN_RESET = CHAN_W'(2);
   localparam logic [CHAN_W-1:0] CHAN_MONO  = CHAN_W'(1);

   localparam int MAX_RESULTS = 64;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP    = 1'b0,
      CSR_CHANNEL_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic prime;
      logic capture;
      logic issue;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic have_prev;
      logic emit_ok;
      logic pipe_free;
   } status_type;

endpackage

>>> sv/lirs_stream_if.sv
interface lirs_req_if #(
   parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface lirs_rsp_if #(
   parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_left;
   logic signed [SAMPLE_BITS-1:0] out_right;
   logic                          last_of_run;

   modport source (output valid, output out_left, output out_right, output last_of_run,
                   input ready);
   modport sink   (input valid, input out_left, input out_right, input last_of_run,
                   output ready);
endinterface

>>> sv/lirs_ctrl.sv
module lirs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lirs_pkg::status_type status,
   output lirs_pkg::cmd_type    cmd
);
   import lirs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.have_prev) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_RUN;
               end else begin
                  cmd.prime = 1'b1;
               end
            end
         end
         ST_RUN: begin
            // emit while the phase is inside the interval and under the result cap, stall on a full pipe
            if (status.emit_ok) begin
               cmd.issue = status.pipe_free;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> sv/lirs_dp.sv
module lirs_dp #(
   parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  lirs_pkg::csr_index_type            csr_index,
   input  logic [lirs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0]      left_sample,
   input  logic signed [SAMPLE_BITS-1:0]      right_sample,
   input  lirs_pkg::cmd_type                  cmd,
   output lirs_pkg::status_type               status,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      out_left,
   output logic signed [SAMPLE_BITS-1:0]      out_right,
   output logic                               last_of_run
);
   import lirs_pkg::*;

   localparam int PHASE_W = ((STEP_W > FRAC_BITS) ? STEP_W : FRAC_BITS + 1) + 1;
   localparam int PROD_W  = SAMPLE_BITS + FRAC_BITS + 2;
   localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] MID_CODE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // configuration
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;

   // frame store and position
   logic signed [SAMPLE_BITS-1:0] prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic signed [SAMPLE_BITS-1:0] cur_l_ff, cur_l_in, cur_r_ff, cur_r_in;
   logic                          have_prev_ff, have_prev_in;
   logic [PHASE_W-1:0]            phase_ff, phase_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;

   // multiply stage
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_last_ff, s1_last_in;
   logic signed [PROD_W-1:0]      s1_prod_l_ff, s1_prod_l_in, s1_prod_r_ff, s1_prod_r_in;
   logic [SAMPLE_BITS-1:0]        s1_base_l_ff, s1_base_l_in, s1_base_r_ff, s1_base_r_in;

   // output register
   logic                          out_valid_ff, out_valid_in;
   logic                          out_last_ff, out_last_in;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_l_in, out_r_ff, out_r_in;

   logic                          mono;
   logic                          advance;
   logic signed [SAMPLE_BITS-1:0] in_r;
   logic [SAMPLE_BITS-1:0]        base_l, base_r, tgt_l, tgt_r;
   logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
   logic signed [FRAC_BITS:0]     frac_s;
   logic signed [PROD_W-1:0]      prod_l, prod_r, rnd_l, rnd_r;
   logic [PHASE_W-1:0]            phase_add;
   logic                          issue_last;
   logic [SAMPLE_BITS+1:0]        sum_l, sum_r;

   assign mono    = (chan_ff == CHAN_MONO);
   assign advance = !out_valid_ff || rsp_ready;
   assign in_r    = mono ? '0 : right_sample;

   // offset-binary operands
   assign base_l = {~prev_l_ff[SAMPLE_BITS-1], prev_l_ff[SAMPLE_BITS-2:0]};
   assign tgt_l  = {~cur_l_ff[SAMPLE_BITS-1], cur_l_ff[SAMPLE_BITS-2:0]};
   assign base_r = mono ? MID_CODE : {~prev_r_ff[SAMPLE_BITS-1], prev_r_ff[SAMPLE_BITS-2:0]};
   assign tgt_r  = mono ? MID_CODE : {~cur_r_ff[SAMPLE_BITS-1], cur_r_ff[SAMPLE_BITS-2:0]};

   assign diff_l = signed'({1'b0, tgt_l}) - signed'({1'b0, base_l});
   assign diff_r = signed'({1'b0, tgt_r}) - signed'({1'b0, base_r});
   assign frac_s = signed'({1'b0, phase_ff[FRAC_BITS-1:0]});
   assign prod_l = diff_l * frac_s;
   assign prod_r = diff_r * frac_s;

   assign phase_add  = phase_ff + PHASE_W'(step_ff);
   assign issue_last = (phase_add >= PHASE_ONE) || (cnt_ff == CNT_W'(MAX_RESULTS - 1));

   // base + round(frac * diff); the result stays inside the sample range
   assign rnd_l = s1_prod_l_ff + ROUND_HALF;
   assign rnd_r = s1_prod_r_ff + ROUND_HALF;
   assign sum_l = {2'b00, s1_base_l_ff} + rnd_l[PROD_W-1:FRAC_BITS];
   assign sum_r = {2'b00, s1_base_r_ff} + rnd_r[PROD_W-1:FRAC_BITS];

   assign status.have_prev = have_prev_ff;
   assign status.emit_ok   = (phase_ff < PHASE_ONE) && (cnt_ff != CNT_W'(MAX_RESULTS));
   assign status.pipe_free = advance;

   always_comb begin
      step_in = step_ff;
      chan_in = chan_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PHASE_STEP:    step_in = csr_wdata[STEP_W-1:0];
            CSR_CHANNEL_COUNT: chan_in = csr_wdata[CHAN_W-1:0];
         endcase
      end
   end

   always_comb begin
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      cur_l_in     = cur_l_ff;
      cur_r_in     = cur_r_ff;
      have_prev_in = have_prev_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      if (cmd.prime) begin
         prev_l_in    = left_sample;
         prev_r_in    = in_r;
         have_prev_in = 1'b1;
      end
      if (cmd.capture) begin
         cur_l_in = left_sample;
         cur_r_in = in_r;
         cnt_in   = '0;
      end
      if (cmd.issue) begin
         phase_in = phase_add;
         cnt_in   = cnt_ff + CNT_W'(1);
      end
      if (cmd.finish) begin
         // drop one interval; a capped run pins the position at zero
         phase_in  = (phase_ff >= PHASE_ONE) ? phase_ff - PHASE_ONE : '0;
         prev_l_in = cur_l_ff;
         prev_r_in = cur_r_ff;
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_last_in   = s1_last_ff;
      s1_prod_l_in = s1_prod_l_ff;
      s1_prod_r_in = s1_prod_r_ff;
      s1_base_l_in = s1_base_l_ff;
      s1_base_r_in = s1_base_r_ff;
      out_valid_in = out_valid_ff;
      out_last_in  = out_last_ff;
      out_l_in     = out_l_ff;
      out_r_in     = out_r_ff;
      if (advance) begin
         s1_valid_in  = cmd.issue;
         s1_last_in   = issue_last;
         s1_prod_l_in = prod_l;
         s1_prod_r_in = prod_r;
         s1_base_l_in = base_l;
         s1_base_r_in = base_r;
         out_valid_in = s1_valid_ff;
         out_last_in  = s1_last_ff;
         out_l_in     = {~sum_l[SAMPLE_BITS-1], sum_l[SAMPLE_BITS-2:0]};
         out_r_in     = {~sum_r[SAMPLE_BITS-1], sum_r[SAMPLE_BITS-2:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         chan_ff      <= CHAN_RESET;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         have_prev_ff <= 1'b0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         chan_ff      <= chan_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         have_prev_ff <= have_prev_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_l_ff     <= cur_l_in;
      cur_r_ff     <= cur_r_in;
      s1_last_ff   <= s1_last_in;
      s1_prod_l_ff <= s1_prod_l_in;
      s1_prod_r_ff <= s1_prod_r_in;
      s1_base_l_ff <= s1_base_l_in;
      s1_base_r_ff <= s1_base_r_in;
      out_last_ff  <= out_last_in;
      out_l_ff     <= out_l_in;
      out_r_ff     <= out_r_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign out_left    = out_l_ff;
   assign out_right   = out_r_ff;
   assign last_of_run = out_last_ff;

endmodule

>>> sv/linear_interp_resampler_unit.sv
// Path: an issued multiply passes the multiply stage and then the output register.
// Flow: a frame that causes results is captured, issues one multiply per result and is then
//   closed, the input staying closed meanwhile; a priming frame only loads the frame store.
// Results stream at one per cycle through the multiply stage and the output register while the receiver takes them.
// Reset: synchronous, active high; clears the previous frame, the read position and all
//   valid flags, and loads the step with 1.0 (at the default FRAC_BITS) and the channel count with stereo.
`include "linear_interp_resampler_unit_macros.svh"

module linear_interp_resampler_unit #(
   parameter int SAMPLE_BITS = lirs_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = lirs_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  lirs_pkg::csr_index_type         csr_index,
   input  logic [lirs_pkg::CSR_DATA_W-1:0] csr_wdata,
   lirs_req_if.sink                        req_ch,
   lirs_rsp_if.source                      rsp_ch
);
   import lirs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: accept a frame, run the emit loop, close the frame
   lirs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, frame store, phase accumulator, multiply and output stages
   lirs_dp #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .left_sample  (req_ch.left_sample),
      .right_sample (req_ch.right_sample),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_ch.valid),
      .rsp_ready    (rsp_ch.ready),
      .out_left     (rsp_ch.out_left),
      .out_right    (rsp_ch.out_right),
      .last_of_run  (rsp_ch.last_of_run)
   );

   // issue only into a free pipe while the position is inside the interval
   `LIRS_ASSERT_IMP(a_issue_ok, clock, reset, cmd.issue, status.pipe_free && status.emit_ok, "issue without room or phase")
   // a captured frame closes the input
   `LIRS_ASSERT_NXT(a_busy_after_capture, clock, reset, cmd.capture, !req_ch.ready, "input open during a run")
   // closing a frame reopens the input
   `LIRS_ASSERT_NXT(a_open_after_finish, clock, reset, cmd.finish, req_ch.ready, "input closed after a run")

endmodule
